@@ rtl/cspr_pkg.sv @@
// Shared types and codes for the crosspoint shadow/restore controller.
`default_nettype none

package cspr_pkg;

  // Field widths fixed by the transaction format
  localparam int unsigned OP_W   = 2;
  localparam int unsigned ROW_W  = 4;
  localparam int unsigned COL_W  = 3;
  localparam int unsigned ADDR_W = 7;

  // Operation codes
  localparam logic [OP_W-1:0] OP_SWITCH  = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR   = 2'd1;
  localparam logic [OP_W-1:0] OP_SAVE    = 2'd2;
  localparam logic [OP_W-1:0] OP_RESTORE = 2'd3;

  // Result kinds
  localparam logic KIND_SWITCH = 1'b0;
  localparam logic KIND_RESET  = 1'b1;

  // Update request from the sequencer to the map store
  typedef struct packed {
    logic             set_bit;
    logic             clear_all;
    logic             save_all;
    logic             restore_row;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             bit_val;
  } map_cmd_t;

endpackage

`default_nettype wire

@@ rtl/cspr_in_if.sv @@
// Input channel: one crosspoint operation per transaction.
`default_nettype none

interface cspr_in_if;
  logic                        valid;
  logic                        ready;
  logic [cspr_pkg::OP_W-1:0]  op;
  logic [cspr_pkg::ROW_W-1:0] row;
  logic [cspr_pkg::COL_W-1:0] col;
  logic                        turn_on;

  modport source (output valid, output op, output row, output col, output turn_on,
                  input ready);
  modport sink (input valid, input op, input row, input col, input turn_on,
                output ready);
endinterface

`default_nettype wire

@@ rtl/cspr_out_if.sv @@
// Output channel: one chip command per transaction.
`default_nettype none

interface cspr_out_if;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [cspr_pkg::ROW_W-1:0]  out_row;
  logic [cspr_pkg::COL_W-1:0]  out_col;
  logic                         connect;
  logic [cspr_pkg::ADDR_W-1:0] address_word;
  logic                         last;

  modport source (output valid, output kind, output out_row, output out_col,
                  output connect, output address_word, output last, input ready);
  modport sink (input valid, input kind, input out_row, input out_col,
                input connect, input address_word, input last, output ready);
endinterface

`default_nettype wire

@@ rtl/crosspoint_shadow_restore_unit.sv @@
// Switch and clear give their command from the output register in the cycle after the transaction is taken.
// Restore scans one column per cycle while the output register is free, one command per differing point.
// Save and no-op transactions give no command.
// Throughput: one transaction per cycle except restore, which holds input ready low for its scan.
// Input waits while the output register holds an untaken command.
// Reset (rst_ni low, asynchronous) clears the shadow map, the snapshot and all control.
`default_nettype none

module crosspoint_shadow_restore_unit #(
  parameter int unsigned ROWS = 16,
  parameter int unsigned COLS = 8
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  cspr_in_if.sink    item_i,
  cspr_out_if.source result_o
);

  cspr_pkg::map_cmd_t         map_cmd;
  logic [cspr_pkg::ROW_W-1:0] rd_row;
  logic [COLS-1:0]            shadow_row;
  logic [COLS-1:0]            saved_row;

  // Sequencer with output register
  cspr_scan #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item_i),
    .result_o     (result_o),
    .cmd_o        (map_cmd),
    .rd_row_o     (rd_row),
    .shadow_row_i (shadow_row),
    .saved_row_i  (saved_row)
  );

  // Shadow and snapshot maps
  cspr_map_store #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_maps (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (map_cmd),
    .rd_row_i     (rd_row),
    .shadow_row_o (shadow_row),
    .saved_row_o  (saved_row)
  );

endmodule

`default_nettype wire

@@ rtl/cspr_map_store.sv @@
// Shadow map and saved snapshot storage with point, row and whole-map updates.
`default_nettype none

module cspr_map_store #(
  parameter int unsigned ROWS = 16,
  parameter int unsigned COLS = 8
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire cspr_pkg::map_cmd_t          cmd_i,
  input  wire logic [cspr_pkg::ROW_W-1:0]  rd_row_i,
  output logic      [COLS-1:0]             shadow_row_o,
  output logic      [COLS-1:0]             saved_row_o
);

  localparam int unsigned RowAw = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned ColAw = (COLS > 1) ? $clog2(COLS) : 1;

  logic [COLS-1:0] shadow_q [ROWS];
  logic [COLS-1:0] saved_q  [ROWS];

  logic [RowAw-1:0] wr_idx;
  logic [RowAw-1:0] rd_idx;
  logic [ColAw-1:0] bit_idx;

  assign wr_idx  = cmd_i.row[RowAw-1:0];
  assign rd_idx  = rd_row_i[RowAw-1:0];
  assign bit_idx = cmd_i.col[ColAw-1:0];

  // Read the addressed row of both maps
  assign shadow_row_o = shadow_q[rd_idx];
  assign saved_row_o  = saved_q[rd_idx];

  // Update shadow: clear all, set/clear one point, or take back a saved row
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < ROWS; r++) shadow_q[r] <= '0;
    end else if (cmd_i.clear_all) begin
      for (int r = 0; r < ROWS; r++) shadow_q[r] <= '0;
    end else if (cmd_i.set_bit) begin
      shadow_q[wr_idx][bit_idx] <= cmd_i.bit_val;
    end else if (cmd_i.restore_row) begin
      shadow_q[wr_idx] <= saved_q[wr_idx];
    end
  end

  // Snapshot the whole shadow map
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < ROWS; r++) saved_q[r] <= '0;
    end else if (cmd_i.save_all) begin
      for (int r = 0; r < ROWS; r++) saved_q[r] <= shadow_q[r];
    end
  end

endmodule

`default_nettype wire

@@ rtl/cspr_scan.sv @@
// Operation sequencer: decodes transactions, scans restore rows a column per cycle while the output is free.
`default_nettype none

module cspr_scan #(
  parameter int unsigned ROWS = 16,
  parameter int unsigned COLS = 8
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  cspr_in_if.sink                          item_i,
  cspr_out_if.source                       result_o,
  output cspr_pkg::map_cmd_t               cmd_o,
  output logic      [cspr_pkg::ROW_W-1:0]  rd_row_o,
  input  wire logic [COLS-1:0]             shadow_row_i,
  input  wire logic [COLS-1:0]             saved_row_i
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic state_q, state_d;

  logic [COLS-1:0]            diff_q, diff_d;
  logic [COLS-1:0]            tgt_q, tgt_d;
  logic [cspr_pkg::COL_W-1:0] col_q, col_d;
  logic [cspr_pkg::ROW_W-1:0] row_q, row_d;

  logic                        out_vld_q, out_vld_d;
  logic                        out_load;
  logic                        kind_q, kind_d;
  logic [cspr_pkg::ROW_W-1:0] orow_q, orow_d;
  logic [cspr_pkg::COL_W-1:0] ocol_q, ocol_d;
  logic                        conn_q, conn_d;
  logic                        last_q, last_d;

  logic            out_free;
  logic            accept;
  logic            row_ok;
  logic            col_ok;
  logic            step;
  logic [COLS-1:0] diff_now;
  logic            rest_zero;

  assign out_free = !out_vld_q || result_o.ready;
  assign item_i.ready = (state_q == ST_IDLE) && out_free;
  assign accept = item_i.valid && item_i.ready;

  assign row_ok = {1'b0, item_i.row} < (cspr_pkg::ROW_W + 1)'(ROWS);
  assign col_ok = {1'b0, item_i.col} < (cspr_pkg::COL_W + 1)'(COLS);

  assign rd_row_o = item_i.row;
  assign diff_now = shadow_row_i ^ saved_row_i;

  // Scan advances while the output register is free; rest_zero: nothing differs above the current column
  assign step      = (state_q == ST_SCAN) && out_free;
  assign rest_zero = (diff_q[COLS-1:1] == '0);

  // Map updates follow accepted operations
  always_comb begin
    cmd_o.set_bit     = accept && (item_i.op == cspr_pkg::OP_SWITCH) && row_ok && col_ok;
    cmd_o.clear_all   = accept && (item_i.op == cspr_pkg::OP_CLEAR);
    cmd_o.save_all    = accept && (item_i.op == cspr_pkg::OP_SAVE);
    cmd_o.restore_row = accept && (item_i.op == cspr_pkg::OP_RESTORE) && row_ok;
    cmd_o.row         = item_i.row;
    cmd_o.col         = item_i.col;
    cmd_o.bit_val     = item_i.turn_on;
  end

  // Sequencer and output register next state
  always_comb begin
    state_d   = state_q;
    diff_d    = diff_q;
    tgt_d     = tgt_q;
    col_d     = col_q;
    row_d     = row_q;
    out_vld_d = out_vld_q && !result_o.ready;
    out_load  = 1'b0;
    kind_d    = kind_q;
    orow_d    = orow_q;
    ocol_d    = ocol_q;
    conn_d    = conn_q;
    last_d    = last_q;

    if (cmd_o.set_bit) begin
      out_load = 1'b1;
      kind_d   = cspr_pkg::KIND_SWITCH;
      orow_d   = item_i.row;
      ocol_d   = item_i.col;
      conn_d   = item_i.turn_on;
      last_d   = 1'b1;
    end else if (cmd_o.clear_all) begin
      out_load = 1'b1;
      kind_d   = cspr_pkg::KIND_RESET;
      orow_d   = '0;
      ocol_d   = '0;
      conn_d   = 1'b0;
      last_d   = 1'b1;
    end else if (cmd_o.restore_row) begin
      // Latch the row difference and the snapshot; scan only if anything differs
      diff_d = diff_now;
      tgt_d  = saved_row_i;
      col_d  = '0;
      row_d  = item_i.row;
      if (diff_now != '0) state_d = ST_SCAN;
    end else if (step) begin
      // Advance one column; emit when it differs
      diff_d = diff_q >> 1;
      tgt_d  = tgt_q >> 1;
      col_d  = col_q + 1'b1;
      if (diff_q[0]) begin
        out_load = 1'b1;
        kind_d   = cspr_pkg::KIND_SWITCH;
        orow_d   = row_q;
        ocol_d   = col_q;
        conn_d   = tgt_q[0];
        last_d   = rest_zero;
        if (rest_zero) state_d = ST_IDLE;
      end
    end

    if (out_load) out_vld_d = 1'b1;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    diff_q <= diff_d;
    tgt_q  <= tgt_d;
    col_q  <= col_d;
    row_q  <= row_d;
    kind_q <= kind_d;
    orow_q <= orow_d;
    ocol_q <= ocol_d;
    conn_q <= conn_d;
    last_q <= last_d;
  end

  assign result_o.valid        = out_vld_q;
  assign result_o.kind         = kind_q;
  assign result_o.out_row      = orow_q;
  assign result_o.out_col      = ocol_q;
  assign result_o.connect      = conn_q;
  assign result_o.address_word = {ocol_q, orow_q};
  assign result_o.last         = last_q;

`ifndef SYNTHESIS
  // A scan only runs while some column still differs
  a_scan_has_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN |-> diff_q != '0)
    else $error("scan running with no differing column");

  // No new transaction is taken while a row scan runs
  a_busy_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN |-> !item_i.ready)
    else $error("input ready during row scan");

  // A pending final command means the scan has finished
  a_last_ends_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && last_q |-> state_q == ST_IDLE)
    else $error("final command pending while scan still running");

  // Chip reset commands are always single and carry a zero address
  a_reset_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && kind_q == cspr_pkg::KIND_RESET |-> last_q && result_o.address_word == '0)
    else $error("malformed chip reset command");
`endif

endmodule

`default_nettype wire

@@ test/cspr_cmd_checker.sv @@
// Checker for the crosspoint controller: tracks the point maps and compares chip commands.
module cspr_cmd_checker
  import cspr_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  cspr_in_if   item_ch,
  cspr_out_if  res_ch,
  output int   fail_cnt_o,
  output int   owed_o,
  output int   ops_seen_o,
  output int   cmds_seen_o
);

  localparam int NROW = 16;
  localparam int NCOL = 8;

  typedef struct packed {
    logic              kind;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic              connect;
    logic [ADDR_W-1:0] addr;
    logic              last;
  } chip_cmd_t;

  logic [NCOL-1:0] shadow_q [NROW];
  logic [NCOL-1:0] saved_q  [NROW];
  chip_cmd_t       owed_cmds [$];
  int              fails;
  int              ops_seen;
  int              cmds_seen;

  function automatic chip_cmd_t make_cmd(input logic kind, input logic [ROW_W-1:0] row,
                                         input logic [COL_W-1:0] col, input logic on,
                                         input logic last);
    chip_cmd_t c;
    c.kind    = kind;
    c.row     = row;
    c.col     = col;
    c.connect = on;
    c.addr    = {col, row};
    c.last    = last;
    return c;
  endfunction

  // Update the maps for one operation and queue the chip commands it owes
  task automatic apply_op(input logic [OP_W-1:0] op, input logic [ROW_W-1:0] row,
                          input logic [COL_W-1:0] col, input logic on);
    int first;
    first = owed_cmds.size();
    case (op)
      OP_SWITCH: begin
        shadow_q[row][col] = on;
        owed_cmds.push_back(make_cmd(KIND_SWITCH, row, col, on, 1'b1));
      end
      OP_CLEAR: begin
        for (int r = 0; r < NROW; r++) shadow_q[r] = '0;
        owed_cmds.push_back(make_cmd(KIND_RESET, '0, '0, 1'b0, 1'b1));
      end
      OP_SAVE: begin
        for (int r = 0; r < NROW; r++) saved_q[r] = shadow_q[r];
      end
      default: begin
        // walk columns upward, one command per point that drifted from the snapshot
        for (int c = 0; c < NCOL; c++) begin
          if (saved_q[row][c] != shadow_q[row][c]) begin
            shadow_q[row][c] = saved_q[row][c];
            owed_cmds.push_back(make_cmd(KIND_SWITCH, row, c[COL_W-1:0],
                                         saved_q[row][c], 1'b0));
          end
        end
        if (owed_cmds.size() > first) owed_cmds[owed_cmds.size()-1].last = 1'b1;
      end
    endcase
  endtask

  task automatic flag(input string what, input chip_cmd_t want, input chip_cmd_t got);
    fails++;
    if (fails <= 10)
      $display("[%0t] %s: want kind=%0d row=%0d col=%0d on=%0d addr=%0d last=%0d, got kind=%0d row=%0d col=%0d on=%0d addr=%0d last=%0d",
               $time, what, want.kind, want.row, want.col, want.connect, want.addr, want.last,
               got.kind, got.row, got.col, got.connect, got.addr, got.last);
  endtask

  // Retire commands against the oldest owed one, then predict the new transaction
  always @(posedge clk_i or negedge rst_ni) begin
    chip_cmd_t got;
    chip_cmd_t want;
    if (!rst_ni) begin
      for (int r = 0; r < NROW; r++) begin
        shadow_q[r] = '0;
        saved_q[r]  = '0;
      end
      owed_cmds.delete();
      fails       = 0;
      ops_seen    = 0;
      cmds_seen   = 0;
      fail_cnt_o  <= 0;
      owed_o      <= 0;
      ops_seen_o  <= 0;
      cmds_seen_o <= 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        got = {res_ch.kind, res_ch.out_row, res_ch.out_col, res_ch.connect,
               res_ch.address_word, res_ch.last};
        cmds_seen++;
        if (owed_cmds.size() == 0) begin
          flag("command with none owed", '0, got);
        end else begin
          want = owed_cmds.pop_front();
          if (got.kind !== want.kind || got.row !== want.row || got.col !== want.col ||
              got.connect !== want.connect || got.addr !== want.addr ||
              got.last !== want.last)
            flag("command mismatch", want, got);
        end
      end
      if (item_ch.valid && item_ch.ready) begin
        ops_seen++;
        apply_op(item_ch.op, item_ch.row, item_ch.col, item_ch.turn_on);
      end
      fail_cnt_o  <= fails;
      owed_o      <= owed_cmds.size();
      ops_seen_o  <= ops_seen;
      cmds_seen_o <= cmds_seen;
    end
  end

endmodule

@@ test/tb_crosspoint_shadow_restore_unit.sv @@
// Testbench top: drives crosspoint operations, stalls the command side and reports the verdict.
module tb_crosspoint_shadow_restore_unit;
  import cspr_pkg::*;

  localparam int OPS_TOTAL = 310;

  logic clk;
  logic rst_n;
  int   fail_cnt;
  int   owed;
  int   ops_seen;
  int   cmds_seen;
  int   burst_left;
  int   sweeps;
  int   sent;

  cspr_in_if  item_if ();
  cspr_out_if res_if ();

  crosspoint_shadow_restore_unit DUT (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .item_i  (item_if.sink),
    .result_o(res_if.source)
  );

  cspr_cmd_checker u_checker (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .item_ch    (item_if),
    .res_ch     (res_if),
    .fail_cnt_o (fail_cnt),
    .owed_o     (owed),
    .ops_seen_o (ops_seen),
    .cmds_seen_o(cmds_seen)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop if the run hangs
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  // Command side: switch between randomly chosen stall patterns
  initial begin
    int mode;
    int span;
    res_if.ready <= 1'b0;
    mode = 0;
    span = 0;
    forever begin
      @(posedge clk);
      if (span == 0) begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(20, 80);
      end
      span--;
      case (mode)
        0:       res_if.ready <= 1'b1;
        1:       res_if.ready <= ($urandom_range(0, 3) != 0);
        2:       res_if.ready <= (span % 4 == 0);
        default: res_if.ready <= ($urandom_range(0, 9) == 0);
      endcase
    end
  end

  // Present one transaction, hold until taken, then continue the burst or idle
  task automatic send_op(input logic [OP_W-1:0] op, input logic [ROW_W-1:0] row,
                         input logic [COL_W-1:0] col, input logic on);
    item_if.valid   <= 1'b1;
    item_if.op      <= op;
    item_if.row     <= row;
    item_if.col     <= col;
    item_if.turn_on <= on;
    sent++;
    @(posedge clk);
    while (!item_if.ready) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      item_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(0, 10);
    end
  endtask

  // Hold off until every owed command is out, then let a restore scan settle
  task automatic drain();
    item_if.valid <= 1'b0;
    @(posedge clk);
    while (owed != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  function automatic logic [OP_W-1:0] pick_op();
    int w;
    w = $urandom_range(0, 99);
    if (w < 45) return OP_SWITCH;
    if (w < 75) return OP_RESTORE;
    if (w < 88) return OP_SAVE;
    return OP_CLEAR;
  endfunction

  initial begin
    int               sel;
    logic [OP_W-1:0]  op;
    logic [ROW_W-1:0] row;
    logic [ROW_W-1:0] hot_row;
    item_if.valid   <= 1'b0;
    item_if.op      <= OP_SWITCH;
    item_if.row     <= '0;
    item_if.col     <= '0;
    item_if.turn_on <= 1'b0;
    rst_n           <= 1'b0;
    burst_left = 0;
    sweeps     = 0;
    sent       = 0;
    hot_row    = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: corner points, a full-row restore, restores toward on and off, no-op restore
    send_op(OP_SWITCH, 4'd0, 3'd0, 1'b1);
    send_op(OP_SWITCH, 4'd15, 3'd7, 1'b1);
    send_op(OP_SWITCH, 4'd15, 3'd7, 1'b0);
    for (int c = 0; c < 8; c++) send_op(OP_SWITCH, 4'd5, c[COL_W-1:0], 1'b1);
    send_op(OP_SAVE, 4'd0, 3'd0, 1'b0);
    send_op(OP_CLEAR, 4'd0, 3'd0, 1'b0);
    send_op(OP_RESTORE, 4'd5, 3'd0, 1'b0);
    send_op(OP_RESTORE, 4'd0, 3'd7, 1'b1);
    send_op(OP_RESTORE, 4'd15, 3'd0, 1'b0);
    send_op(OP_SWITCH, 4'd3, 3'd2, 1'b1);
    send_op(OP_SWITCH, 4'd3, 3'd6, 1'b1);
    send_op(OP_RESTORE, 4'd3, 3'd0, 1'b0);
    send_op(OP_CLEAR, 4'd15, 3'd7, 1'b1);
    send_op(OP_SAVE, 4'd15, 3'd7, 1'b1);
    drain();

    // Random: mostly switches and restores, with whole-map restore sweeps and pauses
    while (sent < OPS_TOTAL) begin
      sel = $urandom_range(0, 99);
      if (sel < 6) begin
        for (int r = 0; r < 16; r++)
          send_op(OP_RESTORE, r[ROW_W-1:0], 3'($urandom), 1'($urandom));
        sweeps++;
      end else if (sel < 8) begin
        drain();
      end else begin
        op  = pick_op();
        row = (op == OP_RESTORE && $urandom_range(0, 1) == 1) ? hot_row : 4'($urandom);
        if (op == OP_SWITCH) hot_row = row;
        send_op(op, row, 3'($urandom), 1'($urandom));
      end
    end

    // Wait out the remaining commands, then a margin for a silent restore scan
    item_if.valid <= 1'b0;
    @(posedge clk);
    while (owed != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d operations and %0d chip commands, including %0d full restore sweeps",
             ops_seen, cmds_seen, sweeps);
    if (fail_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d command failures", fail_cnt);
      $display("simulation failed");
    end
    $finish;
  end

endmodule
